@@ rtl/psg_four_channel_tone_noise_assert.svh @@
// assertion macros for the checker file of the sound generator
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef PSG_FOUR_CHANNEL_TONE_NOISE_ASSERT_SVH
`define PSG_FOUR_CHANNEL_TONE_NOISE_ASSERT_SVH

// checked only outside reset
`define PSG4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PSG4_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/psg4_pkg.sv @@
// shared constants and the attenuation table of the sound generator
// no dependencies
package psg4_pkg;

  // operation codes of an input transfer
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_STEREO = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_FEEDBACK  = 3'd0;
  localparam logic [2:0] CFG_TAP_A     = 3'd1;
  localparam logic [2:0] CFG_TAP_B     = 3'd2;
  localparam logic [2:0] CFG_NEGATE    = 3'd3;
  localparam logic [2:0] CFG_STEREO    = 3'd4;
  localparam logic [2:0] CFG_DIVIDE    = 3'd5;
  localparam logic [2:0] CFG_NCR       = 3'd6;
  localparam logic [2:0] CFG_ZERO_1024 = 3'd7;

  // sound register indexes
  localparam logic [2:0] REG_TONE0 = 3'd0;
  localparam logic [2:0] REG_VOL1  = 3'd3;
  localparam logic [2:0] REG_TONE1 = 3'd2;
  localparam logic [2:0] REG_TONE2 = 3'd4;
  localparam logic [2:0] REG_NOISE = 3'd6;

  localparam logic [1:0]  NOISE_RATE_TONE2 = 2'd3;
  localparam logic [10:0] ZERO_PERIOD      = 11'h400;
  localparam logic [11:0] NOISE_BASE_RATE  = 12'd32;
  localparam logic [16:0] FEEDBACK_RESET   = 17'h10000;
  localparam logic [4:0]  DIVIDE_RESET     = 5'd8;
  localparam logic [4:0]  DIVIDE_MAX       = 5'd16;

  // 8191 / 1.258925412^i, silent at the top code
  function automatic logic [12:0] level_of(input logic [3:0] att);
    logic [12:0] lv;
    case (att)
      4'd0:    lv = 13'd8191;
      4'd1:    lv = 13'd6506;
      4'd2:    lv = 13'd5168;
      4'd3:    lv = 13'd4105;
      4'd4:    lv = 13'd3260;
      4'd5:    lv = 13'd2590;
      4'd6:    lv = 13'd2057;
      4'd7:    lv = 13'd1634;
      4'd8:    lv = 13'd1298;
      4'd9:    lv = 13'd1031;
      4'd10:   lv = 13'd819;
      4'd11:   lv = 13'd650;
      4'd12:   lv = 13'd516;
      4'd13:   lv = 13'd410;
      4'd14:   lv = 13'd326;
      default: lv = 13'd0;
    endcase
    return lv;
  endfunction

endpackage

@@ rtl/psg_four_channel_tone_noise.sv @@
// four-channel tone and noise sound generator, top level
// depends on psg4_pkg
//
//   channel   ports                                   moves
//   input     in_valid/in_ready, in_operation/in_data one write byte, stereo mask or tick
//   result    out_valid/out_ready, out_*_sample       one mixed sample pair per tick
//   config    psel/penable/pwrite/paddr/pwdata/prdata one 32-bit register write or read
//
// one input transfer is taken every cycle while in_ready is high; its result sits in the
// output register from the next cycle on, so throughput is one item per cycle
// in_ready drops only while the output register is full and out_ready is low
// synchronous active-low reset restores all sound state and configuration at once
// writes and mask transfers update state and give no result

module psg_four_channel_tone_noise (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [16:0] feedback_bit_r;
  logic [15:0] tap_a_mask_r;
  logic [15:0] tap_b_mask_r;
  logic        negate_output_r;
  logic        stereo_enable_r;
  logic [4:0]  clock_divide_r;
  logic        ncr_style_r;
  logic        zero_means_1024_r;

  // sound state
  logic [9:0]         reg_file_r      [8];
  logic [9:0]         reg_file_nxt    [8];
  logic [2:0]         latched_index_r, latched_index_nxt;
  logic [12:0]        level_r         [4];
  logic [12:0]        level_nxt       [4];
  logic [10:0]        period_r        [3];   // tone periods, at most 1024
  logic [10:0]        period_nxt      [3];
  logic [11:0]        noise_period_r, noise_period_nxt;
  logic signed [12:0] countdown_r     [4];
  logic signed [12:0] countdown_nxt   [4];
  logic [3:0]         channel_bit_r, channel_bit_nxt;
  logic [16:0]        noise_shift_r, noise_shift_nxt;
  logic [7:0]         stereo_mask_r, stereo_mask_nxt;
  logic [3:0]         divider_count_r, divider_count_nxt;

  // output register
  logic               out_valid_r;
  logic signed [15:0] left_r, right_r;
  logic signed [15:0] left_nxt, right_nxt;

  logic        accept;
  logic        cfg_write;
  logic [2:0]  cfg_index;

  // write byte decode
  logic        latch;
  logic [2:0]  sel;
  logic [9:0]  old_val;
  logic [9:0]  new_val;
  logic        is_tone;
  logic [10:0] tone_period;
  logic [1:0]  noise_rate;

  // chip clock
  logic [4:0]         eff_divide;
  logic signed [12:0] dec [4];
  logic               tap_a_hit;
  logic               tap_b_hit;
  logic               white;
  logic [16:0]        shifted;

  // mixer
  logic [3:0]  mask_l, mask_r;
  logic [14:0] sum_l, sum_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:2];

  always_comb begin
    case (cfg_index)
      psg4_pkg::CFG_FEEDBACK:  prdata = {15'd0, feedback_bit_r};
      psg4_pkg::CFG_TAP_A:     prdata = {16'd0, tap_a_mask_r};
      psg4_pkg::CFG_TAP_B:     prdata = {16'd0, tap_b_mask_r};
      psg4_pkg::CFG_NEGATE:    prdata = {31'd0, negate_output_r};
      psg4_pkg::CFG_STEREO:    prdata = {31'd0, stereo_enable_r};
      psg4_pkg::CFG_DIVIDE:    prdata = {27'd0, clock_divide_r};
      psg4_pkg::CFG_NCR:       prdata = {31'd0, ncr_style_r};
      psg4_pkg::CFG_ZERO_1024: prdata = {31'd0, zero_means_1024_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // write byte: a latch byte picks the register, a data byte reuses the latched one
  assign latch   = in_data[7];
  assign sel     = latch ? in_data[6:4] : latched_index_r;
  assign old_val = reg_file_r[sel];
  assign is_tone = !sel[0] && (sel != psg4_pkg::REG_NOISE);
  // a data byte to a tone register carries the upper six period bits
  assign new_val = (is_tone && !latch) ? {in_data[5:0], old_val[3:0]}
                                       : {old_val[9:4], in_data[3:0]};
  // zero period stands for 1024 where configured
  assign tone_period = ((new_val != 10'd0) || !zero_means_1024_r)
                       ? {1'b0, new_val} : psg4_pkg::ZERO_PERIOD;
  assign noise_rate  = new_val[1:0];

  // divider clamps to 1..16
  always_comb begin
    if (clock_divide_r == 5'd0)
      eff_divide = 5'd1;
    else if (clock_divide_r > psg4_pkg::DIVIDE_MAX)
      eff_divide = psg4_pkg::DIVIDE_MAX;
    else
      eff_divide = clock_divide_r;
  end

  // lfsr taps: the second tap tests for any set bit, or for not all mask bits set
  assign tap_a_hit = |(noise_shift_r[15:0] & tap_a_mask_r);
  assign tap_b_hit = ncr_style_r ? ((noise_shift_r[15:0] & tap_b_mask_r) != tap_b_mask_r)
                                 : |(noise_shift_r[15:0] & tap_b_mask_r);
  assign white     = reg_file_r[psg4_pkg::REG_NOISE][2];
  assign shifted   = (tap_a_hit != (tap_b_hit && white))
                     ? ({1'b0, noise_shift_r[16:1]} | feedback_bit_r)
                     : {1'b0, noise_shift_r[16:1]};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dec[i] = countdown_r[i] - 13'sd1;
    end
  end

  always_comb begin
    reg_file_nxt      = reg_file_r;
    latched_index_nxt = latched_index_r;
    level_nxt         = level_r;
    period_nxt        = period_r;
    noise_period_nxt  = noise_period_r;
    countdown_nxt     = countdown_r;
    channel_bit_nxt   = channel_bit_r;
    noise_shift_nxt   = noise_shift_r;
    stereo_mask_nxt   = stereo_mask_r;
    divider_count_nxt = divider_count_r;

    if (accept) begin
      case (in_operation)
        psg4_pkg::OP_WRITE: begin
          reg_file_nxt[sel] = new_val;
          if (latch) begin
            latched_index_nxt = sel;
            // conditional lfsr reset: only when the white noise bit flips
            if (ncr_style_r && (sel == psg4_pkg::REG_NOISE) &&
                (in_data[2] != reg_file_r[psg4_pkg::REG_NOISE][2]))
              noise_shift_nxt = feedback_bit_r;
          end
          if (is_tone) begin
            period_nxt[sel[2:1]] = tone_period;
            if ((sel == psg4_pkg::REG_TONE2) &&
                (reg_file_r[psg4_pkg::REG_NOISE][1:0] == psg4_pkg::NOISE_RATE_TONE2))
              noise_period_nxt = {tone_period, 1'b0};
          end else if (sel == psg4_pkg::REG_NOISE) begin
            if (noise_rate == psg4_pkg::NOISE_RATE_TONE2)
              noise_period_nxt = {period_r[2], 1'b0};
            else
              noise_period_nxt = psg4_pkg::NOISE_BASE_RATE << noise_rate;
            if (!ncr_style_r)
              noise_shift_nxt = feedback_bit_r;
          end else begin
            level_nxt[sel[2:1]] = psg4_pkg::level_of(in_data[3:0]);
          end
        end
        psg4_pkg::OP_STEREO: begin
          if (stereo_enable_r)
            stereo_mask_nxt = in_data;
        end
        psg4_pkg::OP_TICK: begin
          if (divider_count_r != 4'd0) begin
            divider_count_nxt = divider_count_r - 4'd1;
          end else begin
            divider_count_nxt = 4'(eff_divide - 5'd1);
            for (int i = 0; i < 3; i++) begin
              if (dec[i] <= 13'sd0) begin
                channel_bit_nxt[i] = !channel_bit_r[i];
                countdown_nxt[i]   = signed'({2'b00, period_r[i]});
              end else begin
                countdown_nxt[i]   = dec[i];
              end
            end
            if (dec[3] <= 13'sd0) begin
              noise_shift_nxt    = shifted;
              channel_bit_nxt[3] = shifted[0];
              countdown_nxt[3]   = signed'({1'b0, noise_period_r});
            end else begin
              countdown_nxt[3]   = dec[3];
            end
          end
        end
        default: begin
          // unused code, nothing changes
        end
      endcase
    end
  end

  // mixer works on the channel bits after this tick
  assign mask_l = stereo_enable_r ? stereo_mask_r[7:4] : 4'hf;
  assign mask_r = stereo_enable_r ? stereo_mask_r[3:0] : 4'h0;

  always_comb begin
    sum_l = 15'd0;
    sum_r = 15'd0;
    for (int i = 0; i < 4; i++) begin
      if (mask_l[i] && channel_bit_nxt[i]) sum_l = sum_l + {2'b00, level_r[i]};
      if (mask_r[i] && channel_bit_nxt[i]) sum_r = sum_r + {2'b00, level_r[i]};
    end
    left_nxt  = negate_output_r ? -signed'({1'b0, sum_l}) : signed'({1'b0, sum_l});
    right_nxt = negate_output_r ? -signed'({1'b0, sum_r}) : signed'({1'b0, sum_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feedback_bit_r    <= psg4_pkg::FEEDBACK_RESET;
      tap_a_mask_r      <= 16'd4;
      tap_b_mask_r      <= 16'd8;
      negate_output_r   <= 1'b0;
      stereo_enable_r   <= 1'b0;
      clock_divide_r    <= psg4_pkg::DIVIDE_RESET;
      ncr_style_r       <= 1'b0;
      zero_means_1024_r <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        psg4_pkg::CFG_FEEDBACK:  feedback_bit_r    <= pwdata[16:0];
        psg4_pkg::CFG_TAP_A:     tap_a_mask_r      <= pwdata[15:0];
        psg4_pkg::CFG_TAP_B:     tap_b_mask_r      <= pwdata[15:0];
        psg4_pkg::CFG_NEGATE:    negate_output_r   <= pwdata[0];
        psg4_pkg::CFG_STEREO:    stereo_enable_r   <= pwdata[0];
        psg4_pkg::CFG_DIVIDE:    clock_divide_r    <= pwdata[4:0];
        psg4_pkg::CFG_NCR:       ncr_style_r       <= pwdata[0];
        psg4_pkg::CFG_ZERO_1024: zero_means_1024_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) reg_file_r[i] <= 10'd0;
      // out of reset the latch points at register 3
      latched_index_r <= psg4_pkg::REG_VOL1;
      for (int i = 0; i < 4; i++) begin
        level_r[i]     <= 13'd0;
        countdown_r[i] <= 13'sd0;
      end
      for (int i = 0; i < 3; i++) period_r[i] <= 11'd0;
      noise_period_r  <= 12'd0;
      channel_bit_r   <= {psg4_pkg::FEEDBACK_RESET[0], 3'b000};
      noise_shift_r   <= psg4_pkg::FEEDBACK_RESET;
      stereo_mask_r   <= 8'hff;
      divider_count_r <= 4'(psg4_pkg::DIVIDE_RESET - 5'd1);
      out_valid_r     <= 1'b0;
    end else begin
      reg_file_r      <= reg_file_nxt;
      latched_index_r <= latched_index_nxt;
      level_r         <= level_nxt;
      period_r        <= period_nxt;
      noise_period_r  <= noise_period_nxt;
      countdown_r     <= countdown_nxt;
      channel_bit_r   <= channel_bit_nxt;
      noise_shift_r   <= noise_shift_nxt;
      stereo_mask_r   <= stereo_mask_nxt;
      divider_count_r <= divider_count_nxt;
      if (in_ready)
        out_valid_r <= accept && (in_operation == psg4_pkg::OP_TICK);
    end
  end

  // sample payload, loaded whenever the output register is free
  always_ff @(posedge clk) begin
    if (in_ready) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

@@ rtl/psg4_checker.sv @@
// port-level checks of the sound generator, bound to its top level
// depends on psg4_pkg and psg_four_channel_tone_noise_assert.svh
`include "psg_four_channel_tone_noise_assert.svh"

module psg4_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_operation,
  input logic       out_valid,
  input logic       out_ready
);

  logic tick_taken;
  logic out_free;

  assign tick_taken = in_valid && in_ready && (in_operation == psg4_pkg::OP_TICK);
  assign out_free   = !out_valid || out_ready;

  // a stalled result stays offered
  `PSG4_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // every tick transfer gives a result in the next cycle
  `PSG4_ASSERT(a_tick_result, tick_taken |=> out_valid, "tick without result")

  // a free output register with no tick taken stays empty
  `PSG4_ASSERT(a_no_spurious, out_free && !tick_taken |=> !out_valid, "result without tick")

  // reset empties the output register
  `PSG4_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind psg_four_channel_tone_noise psg4_checker u_psg4_checker (.*);
